// File: design/smoi_pkg.sv
package smoi_pkg;

   localparam int FRAC_BITS = 16;

   localparam int LEN_W      = 32;
   localparam int REL_W      = LEN_W + 1;
   localparam int WW         = 208;
   localparam int YW         = 72;
   localparam int OUT_W      = 48;
   localparam int SUM_W      = 64;
   localparam int PC_W       = 5;
   localparam int DIV_CNT_W  = $clog2(WW + 1);
   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 96;

   // Pi in Q.32, exact as used by the capsule formula.
   localparam logic [YW-1:0] PI_Q32 = YW'(64'd13493037705);
   localparam logic [YW-1:0] K48    = YW'(64'd48);
   localparam logic [YW-1:0] K192   = YW'(64'hC0_0000_0000);
   localparam logic [YW-1:0] KT1    = YW'(64'h10_0000_0000);
   localparam logic [YW-1:0] K6     = YW'(64'd6);
   localparam logic [YW-1:0] K3     = YW'(64'd3);

   localparam logic [WW-1:0] DEN_CIRCLE  = WW'(1) << (2 * FRAC_BITS + 1);
   localparam logic [WW-1:0] DEN_ELLIPSE = WW'(5) << (2 * FRAC_BITS);
   localparam logic [WW-1:0] ONE_3F      = WW'(1) << (3 * FRAC_BITS);
   localparam logic [OUT_W-1:0] SAT48    = {OUT_W{1'b1}};

   localparam logic [PC_W-1:0] PC_CIRCLE    = 5'd0;
   localparam logic [PC_W-1:0] PC_ELLIPSE   = 5'd2;
   localparam logic [PC_W-1:0] PC_CAPSULE   = 5'd5;
   localparam logic [PC_W-1:0] PC_POLY      = 5'd21;
   localparam logic [PC_W-1:0] PC_POLY_LAST = 5'd29;
   localparam logic [PC_W-1:0] PC_POLY_END  = 5'd30;

   typedef enum logic [1:0] {
      KIND_CIRCLE, KIND_VERTEX, KIND_ELLIPSE, KIND_CAPSULE
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ISSUE, ST_MAC_WAIT, ST_POLY_SUM, ST_DIV_ISSUE,
      ST_DIV_WAIT, ST_INV_ISSUE, ST_INV_WAIT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      X_A, X_B, X_S, X_H, X_R1, X_R2, X_R3, X_PX, X_PY, X_CX, X_CY
   } xsel_type;

   typedef enum logic [4:0] {
      Y_A, Y_B, Y_S, Y_H, Y_M, Y_PI, Y_48, Y_192, Y_T1, Y_6, Y_3,
      Y_R1, Y_R2, Y_W, Y_PX, Y_PY, Y_CX, Y_CY, Y_CR
   } ysel_type;

   typedef enum logic [2:0] {
      D_NONE, D_R1, D_R2, D_R3, D_DEN
   } dst_type;

   typedef struct packed {
      xsel_type xsel;
      ysel_type ysel;
      logic     clear;
      logic     inv;
      dst_type  dst;
      logic     last;
   } uop_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic neg;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Multiply-accumulate program for every shape.
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         // Circle: m * a * a.
         5'd0:  u = '{X_A,  Y_A,   1'b1, 1'b0, D_R1,  1'b0};
         5'd1:  u = '{X_R1, Y_M,   1'b1, 1'b0, D_R1,  1'b1};
         // Ellipse: m * (a * a + b * b).
         5'd2:  u = '{X_A,  Y_A,   1'b1, 1'b0, D_NONE, 1'b0};
         5'd3:  u = '{X_B,  Y_B,   1'b0, 1'b0, D_R1,  1'b0};
         5'd4:  u = '{X_R1, Y_M,   1'b1, 1'b0, D_R1,  1'b1};
         // Capsule: divisor first, then the numerator terms.
         5'd5:  u = '{X_S,  Y_S,   1'b1, 1'b0, D_R1,  1'b0};
         5'd6:  u = '{X_H,  Y_S,   1'b1, 1'b0, D_R2,  1'b0};
         5'd7:  u = '{X_R1, Y_PI,  1'b1, 1'b0, D_R3,  1'b0};
         5'd8:  u = '{X_R3, Y_48,  1'b1, 1'b0, D_NONE, 1'b0};
         5'd9:  u = '{X_R2, Y_192, 1'b0, 1'b0, D_DEN, 1'b0};
         5'd10: u = '{X_H,  Y_H,   1'b1, 1'b0, D_NONE, 1'b0};
         5'd11: u = '{X_S,  Y_S,   1'b0, 1'b0, D_R3,  1'b0};
         5'd12: u = '{X_R3, Y_R2,  1'b1, 1'b0, D_R3,  1'b0};
         5'd13: u = '{X_R1, Y_R1,  1'b1, 1'b0, D_R2,  1'b0};
         5'd14: u = '{X_R1, Y_H,   1'b1, 1'b0, D_R1,  1'b0};
         5'd15: u = '{X_R1, Y_W,   1'b1, 1'b0, D_R1,  1'b0};
         5'd16: u = '{X_R2, Y_6,   1'b1, 1'b0, D_NONE, 1'b0};
         5'd17: u = '{X_R1, Y_3,   1'b0, 1'b0, D_R1,  1'b0};
         5'd18: u = '{X_R1, Y_PI,  1'b1, 1'b0, D_NONE, 1'b0};
         5'd19: u = '{X_R3, Y_T1,  1'b0, 1'b0, D_R1,  1'b0};
         5'd20: u = '{X_R1, Y_M,   1'b1, 1'b0, D_R1,  1'b1};
         // Polygon edge: cross product, then the dot terms, then their product.
         5'd21: u = '{X_PX, Y_CY,  1'b1, 1'b0, D_NONE, 1'b0};
         5'd22: u = '{X_PY, Y_CX,  1'b0, 1'b1, D_R1,  1'b0};
         5'd23: u = '{X_CX, Y_CX,  1'b1, 1'b0, D_NONE, 1'b0};
         5'd24: u = '{X_CY, Y_CY,  1'b0, 1'b0, D_NONE, 1'b0};
         5'd25: u = '{X_CX, Y_PX,  1'b0, 1'b0, D_NONE, 1'b0};
         5'd26: u = '{X_CY, Y_PY,  1'b0, 1'b0, D_NONE, 1'b0};
         5'd27: u = '{X_PX, Y_PX,  1'b0, 1'b0, D_NONE, 1'b0};
         5'd28: u = '{X_PY, Y_PY,  1'b0, 1'b0, D_R2,  1'b0};
         5'd29: u = '{X_R2, Y_CR,  1'b1, 1'b0, D_R2,  1'b1};
         // Polygon end: m * cross_dot_sum.
         5'd30: u = '{X_R3, Y_M,   1'b1, 1'b0, D_R1,  1'b1};
         default: u = '{X_A, Y_A, 1'b1, 1'b0, D_NONE, 1'b1};
      endcase
      return u;
   endfunction

endpackage

// File: design/smoi_mac.sv
// Shift-add multiply-accumulate unit: one multiplier bit per cycle, stops
// as soon as the remaining multiplier bits are all zero.
module smoi_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  smoi_pkg::mac_ctl_type         mac_ctl,
   input  logic [smoi_pkg::WW-1:0]       mac_x,
   input  logic [smoi_pkg::YW-1:0]       mac_y,
   output smoi_pkg::unit_stat_type       mac_stat,
   output logic [smoi_pkg::WW-1:0]       mac_acc
);
   import smoi_pkg::*;

   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic [WW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [WW-1:0] acc_ff, acc_in;
   logic [WW-1:0] sum;

   // Subtraction adds the two's complement of the shifted multiplicand.
   assign sum = acc_ff + (x_ff ^ {WW{neg_ff}}) + WW'(neg_ff);

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (mac_ctl.start) begin
         busy_in = 1'b1;
         neg_in  = mac_ctl.neg;
         x_in    = mac_x;
         y_in    = mac_y;
         acc_in  = mac_ctl.clear ? '0 : acc_ff;
      end else if (busy_ff && (y_ff != '0)) begin
         x_in   = x_ff << 1;
         y_in   = y_ff >> 1;
         acc_in = y_ff[0] ? sum : acc_ff;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign mac_stat.busy = busy_ff;
   assign mac_stat.done = busy_ff && (y_ff == '0);
   assign mac_acc       = acc_ff;

endmodule

// File: design/smoi_div.sv
// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module smoi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          div_start,
   input  logic [smoi_pkg::WW-1:0]       div_num,
   input  logic [smoi_pkg::WW-1:0]       div_den,
   output smoi_pkg::unit_stat_type       div_stat,
   output logic [smoi_pkg::WW-1:0]       div_quo
);
   import smoi_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WW-1:0]        quo_ff, quo_in;
   logic [WW-1:0]        rem_ff, rem_in;
   logic [WW-1:0]        den_ff, den_in;
   logic [WW:0]          trial;
   logic [WW:0]          diff;
   logic                 fits;
   logic                 at_end;

   assign trial  = {rem_ff, quo_ff[WW-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign fits   = trial >= {1'b0, den_ff};
   assign at_end = (cnt_ff == DIV_CNT_W'(WW));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_num;
         rem_in  = '0;
         den_in  = div_den;
      end else if (busy_ff && !at_end) begin
         cnt_in = cnt_ff + 1'b1;
         quo_in = {quo_ff[WW-2:0], fits};
         rem_in = fits ? diff[WW-1:0] : trial[WW-1:0];
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = busy_ff && at_end;
   assign div_quo       = quo_ff;

endmodule

// File: design/shape_moment_of_inertia.sv
// Channel  Direction  Ports                        Contents
// req      in         req_tvalid/tready/tdata      one shape or polygon vertex word
//                     req_tuser, req_tlast         shape kind, last polygon vertex
// rsp      out        rsp_tvalid/tready/tdata      inertia and inverse inertia
//                     rsp_tuser                    degenerate flag
//
// An item runs through a short multiply-accumulate program on the shared
// shift-add unit, then through the shared radix-2 divider, once for the
// inertia and once more for the inverse, which is skipped for infinite mass or
// zero inertia; a zero divisor skips both divisions. A polygon vertex that is
// not the last one gives no word.
// Reset is synchronous and clears the sequencer, the output valid flag and the
// polygon sums. A finished word waits in the output register while the next
// item is already accepted; the block stalls only if a second result is ready
// before the first has been taken.
module shape_moment_of_inertia (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mass_value, infinite_mass, size_a, size_b, vertex_x, vertex_y,
   // center_x, center_y, then zero fill
   input  logic [smoi_pkg::REQ_DATA_W-1:0]     req_tdata,
   // shape_kind
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // inertia, inverse_inertia
   output logic [smoi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // degenerate
   output logic [0:0]                          rsp_tuser
);
   import smoi_pkg::*;

   // Magnitude of a two's complement offset.
   function automatic logic [REL_W-1:0] rel_mag(input logic [REL_W-1:0] v);
      return v[REL_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [LEN_W-1:0] mass_ff, mass_in;
   logic             inf_ff, inf_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] a_ff, a_in, b_ff, b_in, s_ff, s_in, h_ff, h_in;
   logic [REL_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [REL_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic             have_prev_ff, have_prev_in;
   logic [SUM_W-1:0] cs_ff, cs_in, cds_ff, cds_in;
   logic [WW-1:0]    r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [WW-1:0]    den_ff, den_in;
   logic [OUT_W-1:0] inertia_ff, inertia_in, inv_ff, inv_in;
   logic             degen_ff, degen_in;
   logic [OUT_W-1:0] out_inertia_ff, out_inertia_in, out_inv_ff, out_inv_in;
   logic             out_degen_ff, out_degen_in;
   logic             out_valid_ff, out_valid_in;

   logic             accept;
   kind_type         req_kind;
   logic [LEN_W-1:0] req_a, req_b;
   logic [REL_W-1:0] req_rel_x, req_rel_y;
   uop_type          uop;
   logic             out_free;

   mac_ctl_type      mac_ctl;
   unit_stat_type    mac_stat;
   logic [WW-1:0]    mac_x, mac_acc;
   logic [YW-1:0]    mac_y;
   logic             x_sgn, y_sgn;

   logic             div_start;
   unit_stat_type    div_stat;
   logic [WW-1:0]    div_num, div_den, div_quo;
   logic [OUT_W-1:0] quo_sat;

   logic [WW-1:0]    cr_abs, cr_shift, cd_shift, den6;
   logic [SUM_W-1:0] cs_add, cds_add, new_cs, new_cds;
   logic [LEN_W+2:0] cap_w;

   assign accept    = req_tvalid && req_tready;
   assign req_kind  = kind_type'(req_tuser);
   assign req_a     = req_tdata[64:33];
   assign req_b     = req_tdata[96:65];
   assign req_rel_x = {req_tdata[128], req_tdata[128:97]} - {req_tdata[192], req_tdata[192:161]};
   assign req_rel_y = {req_tdata[160], req_tdata[160:129]} - {req_tdata[224], req_tdata[224:193]};
   assign uop       = uop_rom(pc_ff);
   assign out_free  = !out_valid_ff || rsp_tready;

   // Capsule helper term 3s + 4h.
   assign cap_w = ({3'b000, s_ff} << 1) + {3'b000, s_ff} + ({3'b000, h_ff} << 2);

   // Polygon edge terms: the signed cross product sits in R1, |cross| * dot in R2.
   assign cr_abs   = r1_ff[WW-1] ? (~r1_ff + 1'b1) : r1_ff;
   assign cr_shift = cr_abs >> FRAC_BITS;
   assign cd_shift = r2_ff >> (3 * FRAC_BITS);
   assign cs_add   = (|cr_shift[WW-1:SUM_W]) ? {SUM_W{1'b1}} : cr_shift[SUM_W-1:0];
   assign cds_add  = (|cd_shift[WW-1:SUM_W]) ? {SUM_W{1'b1}} : cd_shift[SUM_W-1:0];
   assign new_cs   = have_prev_ff ? sat_add(cs_ff, cs_add) : cs_ff;
   assign new_cds  = have_prev_ff ? sat_add(cds_ff, cds_add) : cds_ff;
   assign den6     = (WW'(new_cs) << 2) + (WW'(new_cs) << 1);

   assign quo_sat = (|div_quo[WW-1:OUT_W]) ? SAT48 : div_quo[OUT_W-1:0];

   // Operand selection for the shared multiplier. Polygon offsets enter as
   // magnitudes; their signs set the direction of the accumulation.
   always_comb begin
      x_sgn = 1'b0;
      case (uop.xsel)
         X_A:  mac_x = WW'(a_ff);
         X_B:  mac_x = WW'(b_ff);
         X_S:  mac_x = WW'(s_ff);
         X_H:  mac_x = WW'(h_ff);
         X_R1: mac_x = r1_ff;
         X_R2: mac_x = r2_ff;
         X_R3: mac_x = r3_ff;
         X_PX: begin
            mac_x = WW'(rel_mag(prev_x_ff));
            x_sgn = prev_x_ff[REL_W-1];
         end
         X_PY: begin
            mac_x = WW'(rel_mag(prev_y_ff));
            x_sgn = prev_y_ff[REL_W-1];
         end
         X_CX: begin
            mac_x = WW'(rel_mag(cur_x_ff));
            x_sgn = cur_x_ff[REL_W-1];
         end
         X_CY: begin
            mac_x = WW'(rel_mag(cur_y_ff));
            x_sgn = cur_y_ff[REL_W-1];
         end
         default: mac_x = '0;
      endcase
   end

   always_comb begin
      y_sgn = 1'b0;
      case (uop.ysel)
         Y_A:   mac_y = YW'(a_ff);
         Y_B:   mac_y = YW'(b_ff);
         Y_S:   mac_y = YW'(s_ff);
         Y_H:   mac_y = YW'(h_ff);
         Y_M:   mac_y = YW'(mass_ff);
         Y_PI:  mac_y = PI_Q32;
         Y_48:  mac_y = K48;
         Y_192: mac_y = K192;
         Y_T1:  mac_y = KT1;
         Y_6:   mac_y = K6;
         Y_3:   mac_y = K3;
         Y_R1:  mac_y = r1_ff[YW-1:0];
         Y_R2:  mac_y = r2_ff[YW-1:0];
         Y_W:   mac_y = YW'(cap_w);
         Y_PX: begin
            mac_y = YW'(rel_mag(prev_x_ff));
            y_sgn = prev_x_ff[REL_W-1];
         end
         Y_PY: begin
            mac_y = YW'(rel_mag(prev_y_ff));
            y_sgn = prev_y_ff[REL_W-1];
         end
         Y_CX: begin
            mac_y = YW'(rel_mag(cur_x_ff));
            y_sgn = cur_x_ff[REL_W-1];
         end
         Y_CY: begin
            mac_y = YW'(rel_mag(cur_y_ff));
            y_sgn = cur_y_ff[REL_W-1];
         end
         Y_CR:  mac_y = cr_abs[YW-1:0];
         default: mac_y = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_VERTEX && !have_prev_ff) begin
                  state_in = ST_POLY_SUM;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: state_in = ST_MAC_WAIT;
         ST_MAC_WAIT: begin
            if (mac_stat.done) begin
               if (!uop.last) begin
                  state_in = ST_ISSUE;
               end else if (pc_ff == PC_POLY_LAST) begin
                  state_in = ST_POLY_SUM;
               end else begin
                  state_in = ST_DIV_ISSUE;
               end
            end
         end
         ST_POLY_SUM: state_in = last_ff ? ST_ISSUE : ST_IDLE;
         ST_DIV_ISSUE: state_in = (den_ff == '0) ? ST_DONE : ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = (!inf_ff && quo_sat != '0) ? ST_INV_ISSUE : ST_DONE;
            end
         end
         ST_INV_ISSUE: state_in = ST_INV_WAIT;
         ST_INV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      mac_ctl.start = (state_ff == ST_ISSUE);
      mac_ctl.clear = uop.clear;
      mac_ctl.neg   = x_sgn ^ y_sgn ^ uop.inv;
      div_start     = ((state_ff == ST_DIV_ISSUE) && (den_ff != '0))
                      || (state_ff == ST_INV_ISSUE);
      div_num       = (state_ff == ST_INV_ISSUE) ? ONE_3F : r1_ff;
      div_den       = (state_ff == ST_INV_ISSUE) ? WW'(inertia_ff) : den_ff;
   end

   // Datapath registers.
   always_comb begin
      pc_in          = pc_ff;
      mass_in        = mass_ff;
      inf_in         = inf_ff;
      last_in        = last_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      s_in           = s_ff;
      h_in           = h_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      have_prev_in   = have_prev_ff;
      cs_in          = cs_ff;
      cds_in         = cds_ff;
      r1_in          = r1_ff;
      r2_in          = r2_ff;
      r3_in          = r3_ff;
      den_in         = den_ff;
      inertia_in     = inertia_ff;
      inv_in         = inv_ff;
      degen_in       = degen_ff;
      out_inertia_in = out_inertia_ff;
      out_inv_in     = out_inv_ff;
      out_degen_in   = out_degen_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mass_in  = req_tdata[31:0];
               inf_in   = req_tdata[32];
               last_in  = req_tlast;
               a_in     = req_a;
               b_in     = req_b;
               // The capsule is ordered so that s is the shorter side.
               s_in     = (req_a >= req_b) ? req_b : req_a;
               h_in     = (req_a >= req_b) ? (req_a - req_b) : (req_b - req_a);
               cur_x_in = req_rel_x;
               cur_y_in = req_rel_y;
               case (req_kind)
                  KIND_CIRCLE: begin
                     pc_in  = PC_CIRCLE;
                     den_in = DEN_CIRCLE;
                  end
                  KIND_ELLIPSE: begin
                     pc_in  = PC_ELLIPSE;
                     den_in = DEN_ELLIPSE;
                  end
                  KIND_CAPSULE: pc_in = PC_CAPSULE;
                  default: pc_in = PC_POLY;
               endcase
            end
         end
         ST_MAC_WAIT: begin
            if (mac_stat.done) begin
               if (!uop.last) begin
                  pc_in = pc_ff + 1'b1;
               end
               case (uop.dst)
                  D_R1:  r1_in  = mac_acc;
                  D_R2:  r2_in  = mac_acc;
                  D_R3:  r3_in  = mac_acc;
                  D_DEN: den_in = mac_acc << (2 * FRAC_BITS);
                  default: ;
               endcase
            end
         end
         ST_POLY_SUM: begin
            if (last_ff) begin
               // Close the polygon: hand the sums to the end program and
               // return the running state to zero.
               pc_in        = PC_POLY_END;
               den_in       = den6;
               r3_in        = WW'(new_cds);
               cs_in        = '0;
               cds_in       = '0;
               prev_x_in    = '0;
               prev_y_in    = '0;
               have_prev_in = 1'b0;
            end else begin
               cs_in        = new_cs;
               cds_in       = new_cds;
               prev_x_in    = cur_x_ff;
               prev_y_in    = cur_y_ff;
               have_prev_in = 1'b1;
            end
         end
         ST_DIV_ISSUE: begin
            inv_in = '0;
            if (den_ff == '0) begin
               inertia_in = '0;
               degen_in   = 1'b1;
            end else begin
               degen_in   = 1'b0;
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               inertia_in = quo_sat;
            end
         end
         ST_INV_WAIT: begin
            if (div_stat.done) begin
               inv_in = quo_sat;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_inertia_in = inertia_ff;
               out_inv_in     = inv_ff;
               out_degen_in   = degen_ff;
               out_valid_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         cs_ff        <= '0;
         cds_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         cs_ff        <= cs_in;
         cds_ff       <= cds_in;
      end
      pc_ff          <= pc_in;
      mass_ff        <= mass_in;
      inf_ff         <= inf_in;
      last_ff        <= last_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      s_ff           <= s_in;
      h_ff           <= h_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      r1_ff          <= r1_in;
      r2_ff          <= r2_in;
      r3_ff          <= r3_in;
      den_ff         <= den_in;
      inertia_ff     <= inertia_in;
      inv_ff         <= inv_in;
      degen_ff       <= degen_in;
      out_inertia_ff <= out_inertia_in;
      out_inv_ff     <= out_inv_in;
      out_degen_ff   <= out_degen_in;
   end

   smoi_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctl  (mac_ctl),
      .mac_x    (mac_x),
      .mac_y    (mac_y),
      .mac_stat (mac_stat),
      .mac_acc  (mac_acc)
   );

   smoi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_stat  (div_stat),
      .div_quo   (div_quo)
   );

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_inv_ff, out_inertia_ff};
   assign rsp_tuser[0] = out_degen_ff;

`ifndef NO_ASSERTIONS
   // The arithmetic units are idle whenever a new item can be taken.
   a_idle_on_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!mac_stat.busy && !div_stat.busy))
      else $error("arithmetic unit busy while accepting");

   // A unit is never restarted in the middle of its work.
   a_mac_no_restart: assert property (@(posedge clock) disable iff (reset)
      mac_ctl.start |-> !mac_stat.busy)
      else $error("multiplier restarted while busy");

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // A degenerate result carries zero inertia and zero inverse.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("degenerate result with nonzero value");

   // An inverse is only ever produced for a nonzero inertia.
   a_inv_needs_inertia: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[95:48] != '0) |-> (rsp_tdata[47:0] != '0))
      else $error("inverse inertia without inertia");
`endif

endmodule
